### rtl/swtq_pkg.sv
// ============================================================================
// swtq_pkg: shared types and constants of the sorted wake-time queue
// Holds the command codes, result kinds and the request record that travels
// from the front part to the back part.
// ============================================================================
package swtq_pkg;

   // Field widths fixed by the interface.
   localparam int TASK_W = 4;
   localparam int TIME_W = 32;

   // Task ids at or above this count are not accepted for insertion.
   localparam int TASK_COUNT = 16;

   // Most tasks woken by one check request.
   localparam int MAX_RESULTS = 8;
   localparam int WAKE_CNT_W  = $clog2(MAX_RESULTS);

   // Request queue between front and back; depth must be a power of two.
   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   typedef enum logic [0:0] {
      OP_INSERT = 1'b0,
      OP_CHECK  = 1'b1
   } op_type;

   typedef enum logic [0:0] {
      KIND_WAKE = 1'b0,
      KIND_DROP = 1'b1
   } kind_type;

   // One queued request. The tick is the wake time for an insert and the
   // current time for a check.
   typedef struct packed {
      op_type              op;
      logic [TASK_W-1:0]   task_id;
      logic [TIME_W-1:0]   tick;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } head_type;

endpackage

### rtl/sorted_wake_time_queue.sv
// ============================================================================
// sorted_wake_time_queue: wake-time sorted sleeper queue
// Keeps sleeping tasks ordered by wake tick and reports woken and dropped
// tasks.
// ============================================================================
//
// A request is taken when start is high and busy is low; the receiver of
// results cannot stall, so every result appears for exactly one cycle with
// rsp_strobe high and must be captured then. Requests land in a two-entry
// queue, so up to two may be taken while earlier work is still going on, and
// busy rises only when that queue is full. In an insert, all slots of the
// slot list compare their wake tick to the new one at once, and
// the list shifts open behind the last entry whose tick is equal or earlier.
// If the list is full, either the new task (when no slot is later) or the
// displaced tail is reported with rsp_kind set to drop. Inserts with task ids
// at or above the task count are discarded at intake and give no result. A
// check wakes at most eight tasks, one at a time through the single head-pop
// path of the slot list, and gives no result when nothing is due.
// Each woken task is reported in wake order with rsp_kind clear, and
// rsp_last marks the final result of a request; drop results always carry
// rsp_last. A check that pops eight tasks leaves further due tasks for the
// next check. Times compare as plain unsigned numbers without wrap handling.
// After reset the queue is empty; no clearing pass is needed.
//
module sorted_wake_time_queue #(
   parameter int QUEUE_DEPTH = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_command,
   input  logic [swtq_pkg::TASK_W-1:0]         req_task_id,
   input  logic [swtq_pkg::TIME_W-1:0]         req_wake_time,
   input  logic [swtq_pkg::TIME_W-1:0]         req_now_time,
   output logic                                rsp_strobe,
   output logic                                rsp_kind,
   output logic [swtq_pkg::TASK_W-1:0]         rsp_out_task,
   output logic                                rsp_last
);

   swtq_pkg::head_type        head;
   logic                      pop;
   logic [QUEUE_DEPTH-1:0]    slot_used;

   // Front part: intake, filtering and request buffering.
   swtq_front u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_command   (req_command),
      .req_task_id   (req_task_id),
      .req_wake_time (req_wake_time),
      .req_now_time  (req_now_time),
      .pop           (pop),
      .head          (head)
   );

   // Back part: the sorted slot list and the result register.
   swtq_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .pop          (pop),
      .slot_used    (slot_used),
      .rsp_strobe   (rsp_strobe),
      .rsp_kind     (rsp_kind),
      .rsp_out_task (rsp_out_task),
      .rsp_last     (rsp_last)
   );

`ifndef NO_ASSERTIONS
   // Occupied slots always form a prefix of the slot list.
   assert property (@(posedge clock) disable iff (reset)
      (slot_used & (slot_used + {{(QUEUE_DEPTH-1){1'b0}}, 1'b1})) == '0)
      else $error("slot occupancy is not a prefix");

   // A drop result is always the only, and so the final, result of a request.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_kind == 1'(swtq_pkg::KIND_DROP))) |-> rsp_last)
      else $error("drop result without last");

   // A result is only produced for a request that was waiting in the queue.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(head.valid))
      else $error("result without a pending request");

   // A woken task always comes from an occupied head slot, so it empties
   // the list or leaves the occupancy shifted down by one.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_kind == 1'(swtq_pkg::KIND_WAKE))) |->
      ($countones(slot_used) + 1 == $countones($past(slot_used))))
      else $error("wake without a head pop");
`endif

endmodule

### rtl/swtq_front.sv
// ============================================================================
// swtq_front: request intake of the sorted wake-time queue
// Accepts requests, discards inserts of out-of-range task ids and buffers the
// rest in a short queue for the back part.
// ============================================================================
module swtq_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_command,
   input  logic [swtq_pkg::TASK_W-1:0]         req_task_id,
   input  logic [swtq_pkg::TIME_W-1:0]         req_wake_time,
   input  logic [swtq_pkg::TIME_W-1:0]         req_now_time,
   input  logic                                pop,
   output swtq_pkg::head_type                  head
);

   swtq_pkg::cmd_type                     entry_ff [swtq_pkg::FIFO_DEPTH];
   swtq_pkg::cmd_type                     new_cmd;
   logic [swtq_pkg::FIFO_PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [swtq_pkg::FIFO_PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [swtq_pkg::FIFO_CNT_W-1:0]       count_ff, count_in;
   logic                                  ignored;
   logic                                  push;
   logic                                  do_pop;

   always_comb begin
      new_cmd.op      = (req_command == 1'(swtq_pkg::OP_CHECK)) ?
                        swtq_pkg::OP_CHECK : swtq_pkg::OP_INSERT;
      new_cmd.task_id = req_task_id;
      new_cmd.tick    = (new_cmd.op == swtq_pkg::OP_CHECK) ? req_now_time : req_wake_time;
   end

   assign ignored = (new_cmd.op == swtq_pkg::OP_INSERT) &&
                    (int'(req_task_id) >= swtq_pkg::TASK_COUNT);
   assign busy    = (count_ff == swtq_pkg::FIFO_CNT_W'(swtq_pkg::FIFO_DEPTH));
   assign push    = start && !busy && !ignored;
   assign do_pop  = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_cmd;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.cmd   = entry_ff[rd_ptr_ff];

endmodule

### rtl/swtq_back.sv
// ============================================================================
// swtq_back: slot list of the sorted wake-time queue
// A row of slot cells kept sorted by wake time. Inserts go into all cells at
// once; a check pops one due head entry per cycle.
// ============================================================================
module swtq_back #(
   parameter int QUEUE_DEPTH = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  swtq_pkg::head_type                  head,
   output logic                                pop,
   output logic [QUEUE_DEPTH-1:0]              slot_used,
   output logic                                rsp_strobe,
   output logic                                rsp_kind,
   output logic [swtq_pkg::TASK_W-1:0]         rsp_out_task,
   output logic                                rsp_last
);

   logic [swtq_pkg::TASK_W-1:0]      task_ff [QUEUE_DEPTH];
   logic [swtq_pkg::TASK_W-1:0]      task_in [QUEUE_DEPTH];
   logic [swtq_pkg::TIME_W-1:0]      time_ff [QUEUE_DEPTH];
   logic [swtq_pkg::TIME_W-1:0]      time_in [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0]           used_ff, used_in;
   logic [QUEUE_DEPTH-1:0]           keep;
   logic [swtq_pkg::WAKE_CNT_W-1:0]  wake_cnt_ff, wake_cnt_in;
   logic                             strobe_ff, strobe_in;
   logic                             kind_ff, kind_in;
   logic [swtq_pkg::TASK_W-1:0]      out_task_ff, out_task_in;
   logic                             last_ff, last_in;
   logic                             is_insert;
   logic                             is_check;
   logic                             head_due;
   logic                             next_due;
   logic                             at_limit;
   logic                             wake_last;

   // A cell keeps its entry when it is occupied and not later than the new
   // wake time; since the list is sorted these cells form a prefix.
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         keep[i] = used_ff[i] && (time_ff[i] <= head.cmd.tick);
      end
   end

   assign is_insert = head.valid && (head.cmd.op == swtq_pkg::OP_INSERT);
   assign is_check  = head.valid && (head.cmd.op == swtq_pkg::OP_CHECK);
   assign head_due  = used_ff[0] && (head.cmd.tick >= time_ff[0]);
   assign next_due  = used_ff[1] && (head.cmd.tick >= time_ff[1]);
   assign at_limit  = (wake_cnt_ff == swtq_pkg::WAKE_CNT_W'(swtq_pkg::MAX_RESULTS - 1));
   assign wake_last = at_limit || !next_due;

   always_comb begin
      task_in     = task_ff;
      time_in     = time_ff;
      used_in     = used_ff;
      wake_cnt_in = wake_cnt_ff;
      strobe_in   = 1'b0;
      kind_in     = 1'(swtq_pkg::KIND_WAKE);
      out_task_in = task_ff[0];
      last_in     = 1'b0;
      pop         = 1'b0;

      if (is_insert) begin
         pop = 1'b1;
         if (keep[QUEUE_DEPTH-1]) begin
            // Every slot is at or before the new time: the new task is dropped.
            strobe_in   = 1'b1;
            kind_in     = 1'(swtq_pkg::KIND_DROP);
            out_task_in = head.cmd.task_id;
            last_in     = 1'b1;
         end else begin
            if (used_ff[QUEUE_DEPTH-1]) begin
               // Full list: the tail entry falls off the end.
               strobe_in   = 1'b1;
               kind_in     = 1'(swtq_pkg::KIND_DROP);
               out_task_in = task_ff[QUEUE_DEPTH-1];
               last_in     = 1'b1;
            end
            if (!keep[0]) begin
               task_in[0] = head.cmd.task_id;
               time_in[0] = head.cmd.tick;
            end
            for (int i = 1; i < QUEUE_DEPTH; i++) begin
               if (!keep[i]) begin
                  if (keep[i-1]) begin
                     task_in[i] = head.cmd.task_id;
                     time_in[i] = head.cmd.tick;
                  end else begin
                     task_in[i] = task_ff[i-1];
                     time_in[i] = time_ff[i-1];
                  end
               end
            end
            used_in = used_ff | {used_ff[QUEUE_DEPTH-2:0], 1'b1};
         end
      end else if (is_check) begin
         if (head_due) begin
            strobe_in   = 1'b1;
            kind_in     = 1'(swtq_pkg::KIND_WAKE);
            out_task_in = task_ff[0];
            last_in     = wake_last;
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
               task_in[i] = task_ff[i+1];
               time_in[i] = time_ff[i+1];
            end
            used_in = {1'b0, used_ff[QUEUE_DEPTH-1:1]};
            if (wake_last) begin
               pop         = 1'b1;
               wake_cnt_in = '0;
            end else begin
               wake_cnt_in = wake_cnt_ff + 1'b1;
            end
         end else begin
            pop         = 1'b1;
            wake_cnt_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff     <= '0;
         wake_cnt_ff <= '0;
         strobe_ff   <= 1'b0;
      end else begin
         used_ff     <= used_in;
         wake_cnt_ff <= wake_cnt_in;
         strobe_ff   <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      task_ff     <= task_in;
      time_ff     <= time_in;
      kind_ff     <= kind_in;
      out_task_ff <= out_task_in;
      last_ff     <= last_in;
   end

   assign slot_used    = used_ff;
   assign rsp_strobe   = strobe_ff;
   assign rsp_kind     = kind_ff;
   assign rsp_out_task = out_task_ff;
   assign rsp_last     = last_ff;

endmodule

### bench/testbench.sv
// ============================================================================
// testbench: self-checking bench for the sorted wake-time queue
// Drives insert and check requests, predicts every woken and dropped task
// from a local copy of the sleeper list, and compares each result as it
// appears on the result strobe.
// ============================================================================
module testbench;

   // The list depth matches the default of the block.
   localparam int QDEPTH      = 8;
   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 16;

   // One expected result: a woken or dropped task and its last flag.
   typedef struct {
      swtq_pkg::kind_type          kind;
      logic [swtq_pkg::TASK_W-1:0] task_id;
      logic                        last;
   } report_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic                        busy;
   logic                        req_command = 1'b0;
   logic [swtq_pkg::TASK_W-1:0] req_task_id = '0;
   logic [swtq_pkg::TIME_W-1:0] req_wake_time = '0;
   logic [swtq_pkg::TIME_W-1:0] req_now_time = '0;
   logic                        rsp_strobe;
   logic                        rsp_kind;
   logic [swtq_pkg::TASK_W-1:0] rsp_out_task;
   logic                        rsp_last;

   // Local copy of the sleeper list, kept sorted with the earliest at index 0.
   logic [swtq_pkg::TASK_W-1:0] sleeper_id [QDEPTH];
   logic [swtq_pkg::TIME_W-1:0] sleeper_tick [QDEPTH];
   int                          sleeper_count = 0;

   // Results predicted but not yet seen on the result port, oldest first.
   report_type expected_reports[$];

   int unsigned error_count   = 0;
   int unsigned cycle_count   = 0;
   int unsigned insert_count  = 0;
   int unsigned check_count   = 0;
   int unsigned wake_seen     = 0;
   int unsigned drop_seen     = 0;
   int unsigned burst_left    = 0;

   sorted_wake_time_queue dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_command   (req_command),
      .req_task_id   (req_task_id),
      .req_wake_time (req_wake_time),
      .req_now_time  (req_now_time),
      .rsp_strobe    (rsp_strobe),
      .rsp_kind      (rsp_kind),
      .rsp_out_task  (rsp_out_task),
      .rsp_last      (rsp_last)
   );

   always #6 clock = ~clock;

   // --------------------------------------------------------------------------
   // Prediction
   // --------------------------------------------------------------------------

   function automatic void note_report(input swtq_pkg::kind_type kind,
                                       input logic [swtq_pkg::TASK_W-1:0] id,
                                       input logic last);
      report_type r;
      r.kind    = kind;
      r.task_id = id;
      r.last    = last;
      expected_reports.push_back(r);
   endfunction

   // A new sleeper goes behind every entry with an equal or earlier tick. On a
   // full list either the newcomer or the displaced tail is reported as dropped.
   function automatic void predict_insert(input logic [swtq_pkg::TASK_W-1:0] id,
                                          input logic [swtq_pkg::TIME_W-1:0] wake);
      int n;
      int p;
      n = sleeper_count;
      p = 0;
      if (id >= swtq_pkg::TASK_COUNT) begin
         return;
      end
      while (p < n && sleeper_tick[p] <= wake) begin
         p++;
      end
      if (p >= QDEPTH) begin
         note_report(swtq_pkg::KIND_DROP, id, 1'b1);
         return;
      end
      if (n >= QDEPTH) begin
         note_report(swtq_pkg::KIND_DROP, sleeper_id[QDEPTH-1], 1'b1);
         n = QDEPTH - 1;
      end
      for (int i = n; i > p; i--) begin
         sleeper_id[i]   = sleeper_id[i-1];
         sleeper_tick[i] = sleeper_tick[i-1];
      end
      sleeper_id[p]   = id;
      sleeper_tick[p] = wake;
      sleeper_count   = n + 1;
   endfunction

   // Pops due heads in order, at most MAX_RESULTS of them, stopping early when
   // the list runs empty. The final popped task carries the last flag.
   function automatic void predict_check(input logic [swtq_pkg::TIME_W-1:0] now);
      int k;
      k = 0;
      while (k < swtq_pkg::MAX_RESULTS && sleeper_count > 0 &&
             now >= sleeper_tick[0]) begin
         note_report(swtq_pkg::KIND_WAKE, sleeper_id[0], 1'b0);
         k++;
         for (int i = 0; i < QDEPTH - 1; i++) begin
            sleeper_id[i]   = sleeper_id[i+1];
            sleeper_tick[i] = sleeper_tick[i+1];
         end
         sleeper_count--;
      end
      if (k > 0) begin
         expected_reports[$].last = 1'b1;
      end
   endfunction

   // --------------------------------------------------------------------------
   // Result checking. Outputs are sampled at the edge that ends their cycle,
   // so the values read here are the ones held during that cycle.
   // --------------------------------------------------------------------------

   always @(posedge clock) begin
      report_type want;
      if (!reset && $isunknown(rsp_strobe)) begin
         $display("%0t: result strobe is unknown", $time);
         error_count++;
      end else if (!reset && rsp_strobe) begin
         if (rsp_kind == swtq_pkg::KIND_WAKE) begin
            wake_seen++;
         end else begin
            drop_seen++;
         end
         if (expected_reports.size() == 0) begin
            $display("%0t: unexpected result kind %0d task %0d last %0d",
                     $time, rsp_kind, rsp_out_task, rsp_last);
            error_count++;
         end else begin
            want = expected_reports.pop_front();
            if (rsp_kind !== want.kind) begin
               $display("%0t: kind mismatch, expected %0d, got %0d",
                        $time, want.kind, rsp_kind);
               error_count++;
            end
            if (rsp_out_task !== want.task_id) begin
               $display("%0t: task mismatch, expected %0d, got %0d",
                        $time, want.task_id, rsp_out_task);
               error_count++;
            end
            if (rsp_last !== want.last) begin
               $display("%0t: last flag mismatch, expected %0d, got %0d",
                        $time, want.last, rsp_last);
               error_count++;
            end
         end
      end
   end

   // A stuck handshake or a missing result ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: run limit reached with %0d results outstanding",
                  $time, expected_reports.size());
         $display("testbench: done, errors");
         $finish;
      end
   end

   // --------------------------------------------------------------------------
   // Request side
   // --------------------------------------------------------------------------

   // Between requests the sender either keeps going inside a burst or drops
   // start for a random gap. Now and then a long burst runs with no gap at all,
   // which can fill the two-entry intake and raise busy.
   task automatic pace_sender();
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 6);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
         if ($urandom_range(0, 7) == 0) begin
            burst_left = $urandom_range(20, 40);
         end else begin
            burst_left = $urandom_range(0, 8);
         end
      end else begin
         burst_left--;
      end
   endtask

   // Presents one request and holds it until an edge with busy low takes it.
   // The field that the command does not use carries random bits. Called right
   // after a rising edge, and returns right after one.
   task automatic send_request(input swtq_pkg::op_type op,
                               input logic [swtq_pkg::TASK_W-1:0] id,
                               input logic [swtq_pkg::TIME_W-1:0] tick);
      start         <= 1'b1;
      req_command   <= op;
      req_task_id   <= id;
      req_wake_time <= (op == swtq_pkg::OP_INSERT) ? tick : $urandom();
      req_now_time  <= (op == swtq_pkg::OP_CHECK) ? tick : $urandom();
      do begin
         @(posedge clock);
      end while (busy !== 1'b0);
      if (op == swtq_pkg::OP_INSERT) begin
         insert_count++;
         predict_insert(id, tick);
      end else begin
         check_count++;
         predict_check(tick);
      end
      pace_sender();
   endtask

   task automatic wait_for_drain();
      start <= 1'b0;
      while (expected_reports.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // --------------------------------------------------------------------------
   // Tests
   // --------------------------------------------------------------------------

   // Wake order, ties, and the extremes of the tick range. A check on an empty
   // list and a check whose head is one tick short must both stay silent.
   task automatic test_order_and_ties();
      send_request(swtq_pkg::OP_CHECK,  4'd3,  32'd0);
      send_request(swtq_pkg::OP_INSERT, 4'd0,  32'hFFFF_FFFF);
      send_request(swtq_pkg::OP_INSERT, 4'd15, 32'd0);
      send_request(swtq_pkg::OP_INSERT, 4'd5,  32'd100);
      send_request(swtq_pkg::OP_INSERT, 4'd6,  32'd100);
      send_request(swtq_pkg::OP_CHECK,  4'd0,  32'd99);
      send_request(swtq_pkg::OP_CHECK,  4'd0,  32'd100);
      send_request(swtq_pkg::OP_CHECK,  4'd0,  32'hFFFF_FFFE);
      send_request(swtq_pkg::OP_CHECK,  4'd0,  32'hFFFF_FFFF);
      wait_for_drain();
   endtask

   // Fills the list, then drops a newcomer that ties the tail, displaces the
   // tail with an earlier newcomer, and drops a newcomer at the top tick. A
   // final check pops all eight sleepers in one go and empties the list.
   task automatic test_full_queue();
      for (int i = 0; i < QDEPTH; i++) begin
         send_request(swtq_pkg::OP_INSERT, swtq_pkg::TASK_W'(i + 1),
                      swtq_pkg::TIME_W'(10 * (i + 1)));
      end
      send_request(swtq_pkg::OP_INSERT, 4'd9,  32'd80);
      send_request(swtq_pkg::OP_INSERT, 4'd10, 32'd5);
      send_request(swtq_pkg::OP_INSERT, 4'd11, 32'hFFFF_FFFF);
      send_request(swtq_pkg::OP_CHECK,  4'd0,  32'hFFFF_FFFF);
      wait_for_drain();
   endtask

   // Mostly well-formed traffic around a running tick: sleepers are queued a
   // little ahead of it, often on the same tick, and checks advance it in
   // small steps. A few checks jump far ahead to wake many at once, and a few
   // look back in time. Halfway the sender stops until every outstanding
   // result has come back.
   task automatic test_random_schedule(input int count);
      logic [swtq_pkg::TIME_W-1:0] tick_now;
      int roll;
      tick_now = $urandom_range(0, 1000);
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(0, 99);
         if (n == count / 2) begin
            wait_for_drain();
         end
         if (roll < 58) begin
            send_request(swtq_pkg::OP_INSERT, swtq_pkg::TASK_W'($urandom_range(0, 15)),
                         tick_now + 4 * $urandom_range(0, 10));
         end else if (roll < 93) begin
            tick_now = tick_now + $urandom_range(0, 8);
            send_request(swtq_pkg::OP_CHECK, swtq_pkg::TASK_W'($urandom_range(0, 15)),
                         tick_now);
         end else if (roll < 97) begin
            tick_now = tick_now + $urandom_range(100, 300);
            send_request(swtq_pkg::OP_CHECK, swtq_pkg::TASK_W'($urandom_range(0, 15)),
                         tick_now);
         end else begin
            send_request(swtq_pkg::OP_CHECK, swtq_pkg::TASK_W'($urandom_range(0, 15)),
                         tick_now - $urandom_range(50, 500));
         end
      end
      wait_for_drain();
   endtask

   // Mixed traffic again, but over the whole 32-bit tick range: the running tick
   // starts anywhere, including near the top where sums wrap, and some requests
   // carry fully random ticks. A check at the largest tick closes the test.
   task automatic test_wide_ticks(input int count);
      logic [swtq_pkg::TIME_W-1:0] tick_now;
      int roll;
      tick_now = $urandom();
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < 20) begin
            send_request(swtq_pkg::OP_INSERT, swtq_pkg::TASK_W'($urandom_range(0, 15)),
                         $urandom());
         end else if (roll < 55) begin
            send_request(swtq_pkg::OP_INSERT, swtq_pkg::TASK_W'($urandom_range(0, 15)),
                         tick_now + $urandom_range(0, 64));
         end else if (roll < 70) begin
            send_request(swtq_pkg::OP_CHECK, swtq_pkg::TASK_W'($urandom_range(0, 15)),
                         $urandom());
         end else begin
            tick_now = tick_now + $urandom_range(0, 24);
            send_request(swtq_pkg::OP_CHECK, swtq_pkg::TASK_W'($urandom_range(0, 15)),
                         tick_now);
         end
      end
      send_request(swtq_pkg::OP_CHECK, 4'd0, 32'hFFFF_FFFF);
      wait_for_drain();
   endtask

   // --------------------------------------------------------------------------
   // Sequence
   // --------------------------------------------------------------------------

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_order_and_ties();
      test_full_queue();
      test_random_schedule(370);
      test_wide_ticks(85);

      // Inserts give no result, so one may still be in the list logic after
      // the last result; let the block settle before the verdict.
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("summary: %0d inserts and %0d checks over %0d cycles",
               insert_count, check_count, cycle_count);
      $display("summary: %0d woken and %0d dropped tasks compared, %0d errors",
               wake_seen, drop_seen, error_count);
      if (error_count == 0 && expected_reports.size() == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
